// ===== src/pneumatic_cylinder_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Pneumatic cylinder controller assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PNEUMATIC_CYLINDER_CONTROLLER_ASSERT_SVH
`define PNEUMATIC_CYLINDER_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCC_CHECK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg
// Types, constants and the position classifier of the cylinder controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  localparam int unsigned CntW          = 16;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned GapTicksDef   = 5;
  localparam logic [CntW-1:0] TimeoutRst = 16'd5000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SINGLE_OUTPUT = 3'd0,
    CFG_NO_RETRACT    = 3'd1,
    CFG_NO_EXTEND     = 3'd2,
    CFG_SETTLE_EXTEND = 3'd3,
    CFG_SETTLE_RETRACT = 3'd4,
    CFG_TIMEOUT       = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    POS_RETRACTED = 2'd0,
    POS_EXTENDED  = 2'd1,
    POS_MOVING    = 2'd2
  } pos_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_GAP    = 4'b0010,
    PH_WAIT   = 4'b0100,
    PH_SETTLE = 4'b1000
  } phase_e;

  typedef struct packed {
    logic            single_output_mode;
    logic            no_retract_sensor;
    logic            no_extend_sensor;
    logic [CntW-1:0] settle_extend_ms;
    logic [CntW-1:0] settle_retract_ms;
    logic [CntW-1:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic command;
    logic target_extend;
    logic wait_for_done;
    logic extend_sensor;
    logic retract_sensor;
  } item_t;

  typedef struct packed {
    logic drive_extend;
    logic drive_retract;
    pos_e position;
    logic busy_res;
    logic done_res;
    logic timeout_error;
    logic rejected;
  } result_t;

  // Position wanted for a target bit.
  function automatic pos_e target_pos_f(input logic tgt);
    return tgt ? POS_EXTENDED : POS_RETRACTED;
  endfunction

  // Classify position from the drives and the sensors that are present.
  function automatic pos_e pos_f(input cfg_t cfg, input logic ext_drv, input logic ret_drv,
                                 input logic s_ext, input logic s_ret);
    pos_e o;
    pos_e s;
    if (cfg.single_output_mode) begin
      o = ext_drv ? POS_EXTENDED : POS_RETRACTED;
    end else if (ext_drv && !ret_drv) begin
      o = POS_EXTENDED;
    end else if (ret_drv && !ext_drv) begin
      o = POS_RETRACTED;
    end else begin
      o = POS_MOVING;
    end
    if (cfg.no_retract_sensor || cfg.no_extend_sensor) begin
      if (o == POS_RETRACTED && !cfg.no_retract_sensor && !s_ret) begin
        return POS_MOVING;
      end
      if (o == POS_EXTENDED && !cfg.no_extend_sensor && !s_ext) begin
        return POS_MOVING;
      end
      return o;
    end
    if (s_ret) begin
      s = s_ext ? POS_MOVING : POS_RETRACTED;
    end else begin
      s = s_ext ? POS_EXTENDED : POS_MOVING;
    end
    return (o == s) ? o : POS_MOVING;
  endfunction

endpackage

`default_nettype wire

// ===== src/pcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pcc_cfg_regs
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_cfg_regs (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    wr_en_i,
  input  wire logic [pcc_pkg::CfgIdxW-1:0]  wr_idx_i,
  input  wire logic [pcc_pkg::CfgDataW-1:0] wr_data_i,
  output pcc_pkg::cfg_t                cfg_o
);
  import pcc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        CFG_SINGLE_OUTPUT:  cfg_d.single_output_mode = wr_data_i[0];
        CFG_NO_RETRACT:     cfg_d.no_retract_sensor  = wr_data_i[0];
        CFG_NO_EXTEND:      cfg_d.no_extend_sensor   = wr_data_i[0];
        CFG_SETTLE_EXTEND:  cfg_d.settle_extend_ms   = wr_data_i[CntW-1:0];
        CFG_SETTLE_RETRACT: cfg_d.settle_retract_ms  = wr_data_i[CntW-1:0];
        CFG_TIMEOUT:        cfg_d.timeout_ms         = wr_data_i[CntW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{single_output_mode: 1'b0, no_retract_sensor: 1'b0,
                 no_extend_sensor: 1'b0, settle_extend_ms: '0,
                 settle_retract_ms: '0, timeout_ms: TimeoutRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/pcc_in_stage.sv =====
// ----------------------------------------------------------------------------
// pcc_in_stage
// Input register: captures one item and holds it while the result side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire pcc_pkg::item_t item_i,
  input  wire logic           out_blocked_i,
  output logic                fire_o,
  output pcc_pkg::item_t      item_o
);
  import pcc_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_stall_o = valid_q && out_blocked_i;
  assign fire_o     = valid_q && !out_blocked_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign item_o = item_q;

endmodule

`default_nettype wire

// ===== src/pcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcc_ctrl
// Move sequencer: drive registers, phase machine, gap/settle and timeout counts.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_ctrl #(
  parameter int unsigned GapTicks = pcc_pkg::GapTicksDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pcc_pkg::cfg_t   cfg_i,
  input  wire logic            fire_i,
  input  wire pcc_pkg::item_t  item_i,
  output pcc_pkg::result_t     result_o
);
  import pcc_pkg::*;

  logic            ext_q, ext_d;
  logic            ret_q, ret_d;
  phase_e          phase_q, phase_d;
  logic            tgt_q, tgt_d;
  logic            watch_q, watch_d;
  logic [CntW-1:0] pcnt_q, pcnt_d;
  logic [CntW-1:0] ecnt_q, ecnt_d;
  logic            done, tmo, rej;
  logic            do_finish, do_settle;
  logic [CntW-1:0] settle_val;

  always_comb begin
    ext_d      = ext_q;
    ret_d      = ret_q;
    phase_d    = phase_q;
    tgt_d      = tgt_q;
    watch_d    = watch_q;
    pcnt_d     = pcnt_q;
    ecnt_d     = ecnt_q;
    done       = 1'b0;
    tmo        = 1'b0;
    rej        = 1'b0;
    do_finish  = 1'b0;
    do_settle  = 1'b0;
    settle_val = '0;

    if (item_i.command) begin
      if (phase_q != PH_IDLE) begin
        rej = 1'b1;
      end else if (pos_f(cfg_i, ext_q, ret_q, item_i.extend_sensor, item_i.retract_sensor)
                   == target_pos_f(item_i.target_extend)) begin
        done = 1'b1;
      end else begin
        tgt_d   = item_i.target_extend;
        watch_d = item_i.wait_for_done;
        // break before make: drop the opposite solenoid first
        if (!cfg_i.single_output_mode) begin
          if (item_i.target_extend) begin
            ret_d = 1'b0;
          end else begin
            ext_d = 1'b0;
          end
        end
        if (cfg_i.single_output_mode || GapTicks == 0) begin
          do_finish = 1'b1;
        end else begin
          phase_d = PH_GAP;
          pcnt_d  = CntW'(GapTicks);
        end
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: ;
        PH_GAP: begin
          if (pcnt_q <= CntW'(1)) begin
            do_finish = 1'b1;
          end else begin
            pcnt_d = pcnt_q - CntW'(1);
          end
        end
        PH_WAIT: begin
          if (pos_f(cfg_i, ext_q, ret_q, item_i.extend_sensor, item_i.retract_sensor)
              == target_pos_f(tgt_q)) begin
            do_settle = 1'b1;
          end else if (ecnt_q >= cfg_i.timeout_ms) begin
            tmo     = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            ecnt_d = ecnt_q + CntW'(1);
          end
        end
        PH_SETTLE: begin
          if (pcnt_q <= CntW'(1)) begin
            pcnt_d  = '0;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else begin
            pcnt_d = pcnt_q - CntW'(1);
          end
        end
        default: ;
      endcase
    end

    // target solenoid on
    if (do_finish) begin
      if (cfg_i.single_output_mode) begin
        ext_d = tgt_d;
      end else if (tgt_d) begin
        ext_d = 1'b1;
      end else begin
        ret_d = 1'b1;
      end
      if (!watch_d) begin
        phase_d = PH_IDLE;
        done    = 1'b1;
      end else begin
        ecnt_d = '0;
        if (pos_f(cfg_i, ext_d, ret_d, item_i.extend_sensor, item_i.retract_sensor)
            == target_pos_f(tgt_d)) begin
          do_settle = 1'b1;
        end else begin
          phase_d = PH_WAIT;
        end
      end
    end

    // target reached: settle or complete now
    if (do_settle) begin
      settle_val = tgt_d ? cfg_i.settle_extend_ms : cfg_i.settle_retract_ms;
      if (settle_val == '0) begin
        phase_d = PH_IDLE;
        done    = 1'b1;
      end else begin
        phase_d = PH_SETTLE;
        pcnt_d  = settle_val;
      end
    end
  end

  always_comb begin
    result_o.drive_extend  = ext_d;
    result_o.drive_retract = cfg_i.single_output_mode ? 1'b0 : ret_d;
    result_o.position      = pos_f(cfg_i, ext_d, ret_d, item_i.extend_sensor,
                                   item_i.retract_sensor);
    result_o.busy_res      = (phase_d != PH_IDLE);
    result_o.done_res      = done;
    result_o.timeout_error = tmo;
    result_o.rejected      = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q   <= 1'b0;
      ret_q   <= 1'b0;
      phase_q <= PH_IDLE;
      tgt_q   <= 1'b0;
      watch_q <= 1'b0;
      pcnt_q  <= '0;
      ecnt_q  <= '0;
    end else if (fire_i) begin
      ext_q   <= ext_d;
      ret_q   <= ret_d;
      phase_q <= phase_d;
      tgt_q   <= tgt_d;
      watch_q <= watch_d;
      pcnt_q  <= pcnt_d;
      ecnt_q  <= ecnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/pcc_out_stage.sv =====
// ----------------------------------------------------------------------------
// pcc_out_stage
// Result register with valid/stall toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire pcc_pkg::result_t  result_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output logic                   blocked_o,
  output pcc_pkg::result_t       result_o
);
  import pcc_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign blocked_o = valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!blocked_o) begin
      valid_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!blocked_o && fire_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// ===== src/pneumatic_cylinder_controller.sv =====
// An accepted item is captured in the input register, then passes the sequencer
//   logic into the result register (held back while the result register stalls).
// Throughput: one item per cycle unless stalled; every tick or request is one pass.
// Reset (rst_ni low, asynchronous): drives off, phase idle, counters zero, both
//   handshake stages empty, configuration back to its reset values.
// ----------------------------------------------------------------------------
// pneumatic_cylinder_controller
// Double-acting cylinder control: solenoid drive, position check, settle, timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module pneumatic_cylinder_controller #(
  parameter int unsigned GapTicks = pcc_pkg::GapTicksDef  // break-before-make, 0..65535
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pcc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pcc_pkg::CfgDataW-1:0]  cfg_data_i,
  // item input
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          command_i,
  input  wire logic                          target_extend_i,
  input  wire logic                          wait_for_done_i,
  input  wire logic                          extend_sensor_i,
  input  wire logic                          retract_sensor_i,
  // result output
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               drive_extend_o,
  output logic                               drive_retract_o,
  output logic [1:0]                         position_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic                               timeout_error_o,
  output logic                               rejected_o
);
  import pcc_pkg::*;

  cfg_t    cfg;
  item_t   item_in, item_q;
  result_t result_c, result_q;
  logic    fire;
  logic    out_blocked;

  // Register writes are taken in any cycle; the block is idle by contract.
  assign cfg_ready_o = 1'b1;

  pcc_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  assign item_in = '{command:        command_i,
                     target_extend:  target_extend_i,
                     wait_for_done:  wait_for_done_i,
                     extend_sensor:  extend_sensor_i,
                     retract_sensor: retract_sensor_i};

  // Input register. It stalls only when it holds an item and the result
  // register is full and stalled, so a waiting result never blocks intake
  // by more than one slot.
  pcc_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .item_i        (item_in),
    .out_blocked_i (out_blocked),
    .fire_o        (fire),
    .item_o        (item_q)
  );

  // Sequencer: state advances exactly once per item moved into the result register.
  pcc_ctrl #(
    .GapTicks (GapTicks)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (fire),
    .item_i   (item_q),
    .result_o (result_c)
  );

  pcc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .result_i    (result_c),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .blocked_o   (out_blocked),
    .result_o    (result_q)
  );

  assign drive_extend_o  = result_q.drive_extend;
  assign drive_retract_o = result_q.drive_retract;
  assign position_o      = result_q.position;
  assign busy_res_o      = result_q.busy_res;
  assign done_res_o      = result_q.done_res;
  assign timeout_error_o = result_q.timeout_error;
  assign rejected_o      = result_q.rejected;

endmodule

`default_nettype wire

// ===== src/pcc_checker.sv =====
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks of the cylinder controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pneumatic_cylinder_controller_assert.svh"

module pcc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        drive_extend_o,
  input wire logic        drive_retract_o,
  input wire logic [1:0]  position_o,
  input wire logic        busy_res_o,
  input wire logic        done_res_o,
  input wire logic        timeout_error_o,
  input wire logic        rejected_o
);

  // At most one of completion, timeout and reject per item.
  `PCC_CHECK_SAME(a_one_event, out_valid_o,
    $countones({done_res_o, timeout_error_o, rejected_o}) <= 1,
    "more than one event flag on one item")

  // A move that completes or times out leaves the block idle.
  `PCC_CHECK_SAME(a_end_not_busy, out_valid_o && (done_res_o || timeout_error_o),
    !busy_res_o, "busy after move end")

  // A reject only happens while a move is running, which it does not disturb.
  `PCC_CHECK_SAME(a_reject_busy, out_valid_o && rejected_o, busy_res_o,
    "reject reported while idle")

  // Intake stalls only behind a full, stalled result register.
  `PCC_CHECK_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
    "input stalled without output back-pressure")

  // Stalled result holds.
  `PCC_CHECK_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable({drive_extend_o, drive_retract_o, position_o, busy_res_o,
                            done_res_o, timeout_error_o, rejected_o}),
    "stalled result changed")

endmodule

bind pneumatic_cylinder_controller pcc_checker u_pcc_checker (.*);

`default_nettype wire

// ===== verif/tb_pneumatic_cylinder_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pneumatic_cylinder_controller
// Self-checking bench: a clocked driver feeds ticks and move requests from a
// queue. A cylinder model predicts every result. A clocked monitor compares
// each result field by field, with random idles and stalls on both sides.
// ----------------------------------------------------------------------------

module tb_pneumatic_cylinder_controller;

  import pcc_pkg::*;

  localparam int unsigned CLK_PERIOD  = 12;
  localparam int unsigned GAP_TICKS   = GapTicksDef;
  localparam int unsigned LATENCY     = 2;         // input reg + result reg
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned LONG_HOLD   = 90;        // receiver back-pressure burst

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_MOVE    = 1'b1;
  localparam logic TGT_RETRACT = 1'b0;
  localparam logic TGT_EXTEND  = 1'b1;

  // --------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i       = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic                command_i        = 1'b0;
  logic                target_extend_i  = 1'b0;
  logic                wait_for_done_i  = 1'b0;
  logic                extend_sensor_i  = 1'b0;
  logic                retract_sensor_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic                drive_extend_o;
  logic                drive_retract_o;
  logic [1:0]          position_o;
  logic                busy_res_o;
  logic                done_res_o;
  logic                timeout_error_o;
  logic                rejected_o;

  pneumatic_cylinder_controller #(
    .GapTicks (GAP_TICKS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .target_extend_i  (target_extend_i),
    .wait_for_done_i  (wait_for_done_i),
    .extend_sensor_i  (extend_sensor_i),
    .retract_sensor_i (retract_sensor_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_extend_o   (drive_extend_o),
    .drive_retract_o  (drive_retract_o),
    .position_o       (position_o),
    .busy_res_o       (busy_res_o),
    .done_res_o       (done_res_o),
    .timeout_error_o  (timeout_error_o),
    .rejected_o       (rejected_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Cylinder model: shadow config plus the controller state
  // --------------------------------------------------------------------------
  cfg_t        cfg_shadow;
  logic        drv_ext, drv_ret;
  phase_e      move_ph;
  logic        tgt_q, watch_q;
  logic [15:0] phase_cnt, elapsed_cnt;
  logic        sens_e, sens_r;

  // Queues between the stimulus, the driver and the monitor
  item_t   pending_items[$];
  result_t expected_results[$];

  int unsigned items_queued   = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Where the cylinder sits, judged from drives and the sensors fitted
  function automatic pos_e classify_position();
    pos_e by_drive;
    pos_e by_sensor;
    if (cfg_shadow.single_output_mode) begin
      by_drive = drv_ext ? POS_EXTENDED : POS_RETRACTED;
    end else begin
      case ({drv_ext, drv_ret})
        2'b10:   by_drive = POS_EXTENDED;
        2'b01:   by_drive = POS_RETRACTED;
        default: by_drive = POS_MOVING;
      endcase
    end
    if (cfg_shadow.no_retract_sensor || cfg_shadow.no_extend_sensor) begin
      // a fitted sensor at the driven end must confirm, absent ones are trusted
      if (by_drive == POS_RETRACTED && !cfg_shadow.no_retract_sensor && !sens_r) begin
        return POS_MOVING;
      end
      if (by_drive == POS_EXTENDED && !cfg_shadow.no_extend_sensor && !sens_e) begin
        return POS_MOVING;
      end
      return by_drive;
    end
    case ({sens_e, sens_r})
      2'b10:   by_sensor = POS_EXTENDED;
      2'b01:   by_sensor = POS_RETRACTED;
      default: by_sensor = POS_MOVING;
    endcase
    return (by_drive == by_sensor) ? by_drive : POS_MOVING;
  endfunction

  function automatic logic at_target(input logic tgt);
    return classify_position() == (tgt ? POS_EXTENDED : POS_RETRACTED);
  endfunction

  // Target reached while watching; returns 1 when the move completes now
  function automatic logic start_settle();
    logic [15:0] dly;
    dly = tgt_q ? cfg_shadow.settle_extend_ms : cfg_shadow.settle_retract_ms;
    if (dly == 16'd0) begin
      move_ph = PH_IDLE;
      return 1'b1;
    end
    move_ph   = PH_SETTLE;
    phase_cnt = dly;
    return 1'b0;
  endfunction

  // Turn on the drive toward the target; returns 1 when the move completes now
  function automatic logic energize_target();
    if (cfg_shadow.single_output_mode) begin
      drv_ext = tgt_q;
    end else if (tgt_q) begin
      drv_ext = 1'b1;
    end else begin
      drv_ret = 1'b1;
    end
    if (!watch_q) begin
      move_ph = PH_IDLE;
      return 1'b1;
    end
    elapsed_cnt = 16'd0;
    if (at_target(tgt_q)) begin
      return start_settle();
    end
    move_ph = PH_WAIT;
    return 1'b0;
  endfunction

  // Apply one accepted item to the model and produce the expected result
  task automatic advance_cylinder(input item_t it, output result_t res);
    logic done_p;
    logic tmo_p;
    logic rej_p;
    done_p = 1'b0;
    tmo_p  = 1'b0;
    rej_p  = 1'b0;
    sens_e = it.extend_sensor;
    sens_r = it.retract_sensor;
    if (it.command == CMD_MOVE) begin
      if (move_ph != PH_IDLE) begin
        rej_p = 1'b1;
      end else if (at_target(it.target_extend)) begin
        done_p = 1'b1;
      end else begin
        tgt_q   = it.target_extend;
        watch_q = it.wait_for_done;
        // break before make: drop the opposing solenoid first
        if (!cfg_shadow.single_output_mode) begin
          if (it.target_extend) begin
            drv_ret = 1'b0;
          end else begin
            drv_ext = 1'b0;
          end
        end
        if (cfg_shadow.single_output_mode || GAP_TICKS == 0) begin
          done_p = energize_target();
        end else begin
          move_ph   = PH_GAP;
          phase_cnt = 16'(GAP_TICKS);
        end
      end
    end else begin
      case (move_ph)
        PH_GAP: begin
          if (phase_cnt <= 16'd1) begin
            done_p = energize_target();
          end else begin
            phase_cnt = phase_cnt - 16'd1;
          end
        end
        PH_WAIT: begin
          if (at_target(tgt_q)) begin
            done_p = start_settle();
          end else if (elapsed_cnt >= cfg_shadow.timeout_ms) begin
            tmo_p   = 1'b1;
            move_ph = PH_IDLE;
          end else begin
            elapsed_cnt = elapsed_cnt + 16'd1;
          end
        end
        PH_SETTLE: begin
          if (phase_cnt <= 16'd1) begin
            phase_cnt = 16'd0;
            move_ph   = PH_IDLE;
            done_p    = 1'b1;
          end else begin
            phase_cnt = phase_cnt - 16'd1;
          end
        end
        default: ;
      endcase
    end
    res.drive_extend  = drv_ext;
    res.drive_retract = cfg_shadow.single_output_mode ? 1'b0 : drv_ret;
    res.position      = classify_position();
    res.busy_res      = (move_ph != PH_IDLE);
    res.done_res      = done_p;
    res.timeout_error = tmo_p;
    res.rejected      = rej_p;
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued items, with a random idle gap between them
  // --------------------------------------------------------------------------
  item_t       cur_item;
  int unsigned tx_gap   = 0;
  logic        tx_quiet = 1'b1;

  always @(posedge clk_i) begin : item_driver
    item_t   nxt;
    result_t res;
    logic    vld_n;
    if (rst_ni) begin
      vld_n = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        advance_cylinder(cur_item, res);
        expected_results.push_back(res);
        vld_n = 1'b0;
        items_sent++;
        if (items_sent % 40 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
        end
        tx_gap = tx_quiet ? 0 : $urandom_range(0, 5);
      end
      // a back-to-back item keeps valid high: only one write to in_valid_i here
      if (!vld_n) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_items.size() > 0) begin
          nxt              = pending_items.pop_front();
          cur_item         = nxt;
          command_i        <= nxt.command;
          target_extend_i  <= nxt.target_extend;
          wait_for_done_i  <= nxt.wait_for_done;
          extend_sensor_i  <= nxt.extend_sensor;
          retract_sensor_i <= nxt.retract_sensor;
          vld_n            = 1'b1;
        end
      end
      in_valid_i <= vld_n;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result against the oldest prediction, with a random stall
  // after each item, and two long hold-offs to fill the pipeline
  // --------------------------------------------------------------------------
  int unsigned rx_gap   = 0;
  int unsigned rx_hold  = 0;
  logic        rx_quiet = 1'b1;

  task automatic check_field(input string fname, input logic [1:0] exp_v,
                             input logic [1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    result_t exp_r;
    logic    stall_n;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual pos=%0h",
                   $time, position_o);
          mismatch_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("drive_extend",  2'(exp_r.drive_extend),  2'(drive_extend_o));
          check_field("drive_retract", 2'(exp_r.drive_retract), 2'(drive_retract_o));
          check_field("position",      exp_r.position,          position_o);
          check_field("busy_res",      2'(exp_r.busy_res),      2'(busy_res_o));
          check_field("done_res",      2'(exp_r.done_res),      2'(done_res_o));
          check_field("timeout_error", 2'(exp_r.timeout_error), 2'(timeout_error_o));
          check_field("rejected",      2'(exp_r.rejected),      2'(rejected_o));
        end
        results_seen++;
        if (results_seen == 120 || results_seen == 400) begin
          rx_hold = LONG_HOLD;
        end
        if (results_seen % 50 == 0) begin
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        rx_gap = rx_quiet ? 0 : $urandom_range(0, 5);
      end
      if (rx_hold > 0) begin
        stall_n = 1'b1;
        rx_hold--;
      end else if (rx_gap > 0) begin
        stall_n = 1'b1;
        rx_gap--;
      end else begin
        stall_n = 1'b0;
      end
      out_stall_i <= stall_n;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** pneumatic_cylinder_controller: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_item(input logic cmd, input logic tgt, input logic wt,
                           input logic se, input logic sr);
    item_t it;
    it.command        = cmd;
    it.target_extend  = tgt;
    it.wait_for_done  = wt;
    it.extend_sensor  = se;
    it.retract_sensor = sr;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // One plausible move: request, then ticks where the sensors follow the
  // cylinder after a random travel time, with the odd glitch. Sometimes the
  // cylinder never arrives so the timeout path gets exercised.
  task automatic push_move();
    logic        tgt;
    logic        se;
    logic        sr;
    int unsigned n_ticks;
    int unsigned arrive;
    tgt = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < 7) begin
      push_item(CMD_MOVE, tgt, $urandom_range(0, 3) != 0, !tgt, tgt);
    end else begin
      push_item(CMD_MOVE, tgt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
    n_ticks = $urandom_range(2, 18);
    arrive  = $urandom_range(0, n_ticks + 4);
    for (int k = 0; k < n_ticks; k++) begin
      if (k >= arrive) begin
        se = tgt;
        sr = !tgt;
      end else begin
        se = 1'b0;
        sr = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) begin
        se = 1'($urandom_range(0, 1));
        sr = 1'($urandom_range(0, 1));
      end
      // occasionally a stray request lands mid-move
      if ($urandom_range(0, 19) == 0) begin
        push_item(CMD_MOVE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), se, sr);
      end else begin
        push_item(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), se, sr);
      end
    end
  endtask

  // Block until the input side is empty and every result has come back
  task automatic wait_until_drained();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Random items: mostly move sequences, about one in five pure noise
  task automatic run_phase(input int unsigned n_items);
    int unsigned start_cnt;
    start_cnt = items_queued;
    while (items_queued - start_cnt < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        push_move();
      end
    end
    wait_until_drained();
  endtask

  // Drives a register write and waits until it is taken; leaves cfg_valid_i high for the caller
  task automatic cfg_write(input cfg_idx_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      CFG_SINGLE_OUTPUT:  cfg_shadow.single_output_mode = data[0];
      CFG_NO_RETRACT:     cfg_shadow.no_retract_sensor  = data[0];
      CFG_NO_EXTEND:      cfg_shadow.no_extend_sensor   = data[0];
      CFG_SETTLE_EXTEND:  cfg_shadow.settle_extend_ms   = data;
      CFG_SETTLE_RETRACT: cfg_shadow.settle_retract_ms  = data;
      CFG_TIMEOUT:        cfg_shadow.timeout_ms         = data;
      default: ;
    endcase
  endtask

  // A move may still be in flight here; the model keeps a loaded settle
  // count and reads the timeout live, same as the block.
  task automatic set_config(input logic so, input logic nr, input logic ne,
                            input logic [15:0] st_e, input logic [15:0] st_r,
                            input logic [15:0] tmo);
    cfg_write(CFG_SINGLE_OUTPUT, {15'd0, so});
    cfg_write(CFG_NO_RETRACT, {15'd0, nr});
    cfg_write(CFG_NO_EXTEND, {15'd0, ne});
    cfg_write(CFG_SETTLE_EXTEND, st_e);
    cfg_write(CFG_SETTLE_RETRACT, st_r);
    cfg_write(CFG_TIMEOUT, tmo);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_shadow  = '0;
    cfg_shadow.timeout_ms = TimeoutRst;
    drv_ext     = 1'b0;
    drv_ret     = 1'b0;
    move_ph     = PH_IDLE;
    tgt_q       = 1'b0;
    watch_q     = 1'b0;
    phase_cnt   = 16'd0;
    elapsed_cnt = 16'd0;
    sens_e      = 1'b0;
    sens_r      = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset config: two outputs, both sensors, no settle
    push_item(CMD_TICK, TGT_RETRACT, 1'b0, 1'b0, 1'b0);  // idle, drives off
    push_item(CMD_TICK, TGT_EXTEND,  1'b1, 1'b1, 1'b1);  // both sensors lit
    push_item(CMD_MOVE, TGT_RETRACT, 1'b1, 1'b0, 1'b1);  // starts the gap
    push_item(CMD_MOVE, TGT_EXTEND,  1'b1, 1'b0, 1'b1);  // busy -> rejected
    repeat (4) push_item(CMD_TICK, TGT_RETRACT, 1'b0, 1'b0, 1'b1);
    push_item(CMD_TICK, TGT_RETRACT, 1'b0, 1'b0, 1'b1);  // drive on, met, done
    push_item(CMD_MOVE, TGT_RETRACT, 1'b1, 1'b0, 1'b1);  // already there
    push_item(CMD_MOVE, TGT_EXTEND,  1'b0, 1'b0, 1'b1);  // no wait
    repeat (5) push_item(CMD_TICK, TGT_EXTEND, 1'b0, 1'b0, 1'b0);
    push_item(CMD_MOVE, TGT_RETRACT, 1'b1, 1'b1, 1'b0);  // wait, not there yet
    repeat (5) push_item(CMD_TICK, TGT_RETRACT, 1'b1, 1'b0, 1'b0);
    push_item(CMD_TICK, TGT_RETRACT, 1'b1, 1'b0, 1'b0);
    push_item(CMD_TICK, TGT_RETRACT, 1'b1, 1'b1, 1'b1);
    push_item(CMD_TICK, TGT_RETRACT, 1'b1, 1'b0, 1'b1);  // arrives
    wait_until_drained();

    // Random phases over a spread of settings; zero timeout first
    set_config(1'b0, 1'b0, 1'b0, 16'd3, 16'd1, 16'd0);
    run_phase(85);
    set_config(1'b1, 1'b0, 1'b0, 16'd2, 16'd0, 16'd12);
    run_phase(85);
    set_config(1'b0, 1'b1, 1'b0, 16'd0, 16'd4, 16'd20);
    run_phase(85);
    set_config(1'b0, 1'b0, 1'b1, 16'd1, 16'd2, 16'd6);
    run_phase(85);
    set_config(1'b1, 1'b1, 1'b1, 16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
               16'($urandom_range(0, 25)));
    run_phase(85);
    set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 16'($urandom_range(0, 6)),
               16'($urandom_range(0, 6)), 16'($urandom_range(0, 40)));
    run_phase(85);
    // Max counts last: a settle this long never ends within the run
    set_config(1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(40);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** pneumatic_cylinder_controller: PASSED **");
    end else begin
      $display("** pneumatic_cylinder_controller: FAILED **");
    end
    $finish;
  end

endmodule

// ===== pneumatic_cylinder_controller.f =====
+incdir+src
src/pcc_pkg.sv
src/pcc_cfg_regs.sv
src/pcc_in_stage.sv
src/pcc_ctrl.sv
src/pcc_out_stage.sv
src/pneumatic_cylinder_controller.sv
src/pcc_checker.sv
verif/tb_pneumatic_cylinder_controller.sv
